// ===== rtl/mfd_pkg.sv =====
package mfd_pkg;

  localparam logic [11:0] SF_MANT_MASK = 12'hfff;
  localparam logic [23:0] FL_POS_INF = 24'h7ffffe;
  localparam logic [23:0] FL_NAN_LO = 24'h7fffff;
  localparam logic [23:0] FL_NAN_HI = 24'h800001;
  localparam logic [23:0] FL_NEG_INF = 24'h800002;
  localparam logic [63:0] BITS_POS_INF = 64'h7ff0000000000000;
  localparam logic [63:0] BITS_NEG_INF = 64'hfff0000000000000;
  localparam logic [63:0] BITS_QNAN = 64'h7ff8000000000000;
  localparam logic CMD_SFLOAT = 1'b0;
  localparam logic CMD_FLOAT = 1'b1;

  // binary64 bits of 10^(idx-128), rounded to nearest
  function automatic logic [63:0] pow10_bits(input logic [7:0] idx);
    logic [63:0] r;
    unique case (idx)
      8'd0: r = $realtobits(1e-128);   8'd1: r = $realtobits(1e-127);
      8'd2: r = $realtobits(1e-126);   8'd3: r = $realtobits(1e-125);
      8'd4: r = $realtobits(1e-124);   8'd5: r = $realtobits(1e-123);
      8'd6: r = $realtobits(1e-122);   8'd7: r = $realtobits(1e-121);
      8'd8: r = $realtobits(1e-120);   8'd9: r = $realtobits(1e-119);
      8'd10: r = $realtobits(1e-118);  8'd11: r = $realtobits(1e-117);
      8'd12: r = $realtobits(1e-116);  8'd13: r = $realtobits(1e-115);
      8'd14: r = $realtobits(1e-114);  8'd15: r = $realtobits(1e-113);
      8'd16: r = $realtobits(1e-112);  8'd17: r = $realtobits(1e-111);
      8'd18: r = $realtobits(1e-110);  8'd19: r = $realtobits(1e-109);
      8'd20: r = $realtobits(1e-108);  8'd21: r = $realtobits(1e-107);
      8'd22: r = $realtobits(1e-106);  8'd23: r = $realtobits(1e-105);
      8'd24: r = $realtobits(1e-104);  8'd25: r = $realtobits(1e-103);
      8'd26: r = $realtobits(1e-102);  8'd27: r = $realtobits(1e-101);
      8'd28: r = $realtobits(1e-100);  8'd29: r = $realtobits(1e-99);
      8'd30: r = $realtobits(1e-98);   8'd31: r = $realtobits(1e-97);
      8'd32: r = $realtobits(1e-96);   8'd33: r = $realtobits(1e-95);
      8'd34: r = $realtobits(1e-94);   8'd35: r = $realtobits(1e-93);
      8'd36: r = $realtobits(1e-92);   8'd37: r = $realtobits(1e-91);
      8'd38: r = $realtobits(1e-90);   8'd39: r = $realtobits(1e-89);
      8'd40: r = $realtobits(1e-88);   8'd41: r = $realtobits(1e-87);
      8'd42: r = $realtobits(1e-86);   8'd43: r = $realtobits(1e-85);
      8'd44: r = $realtobits(1e-84);   8'd45: r = $realtobits(1e-83);
      8'd46: r = $realtobits(1e-82);   8'd47: r = $realtobits(1e-81);
      8'd48: r = $realtobits(1e-80);   8'd49: r = $realtobits(1e-79);
      8'd50: r = $realtobits(1e-78);   8'd51: r = $realtobits(1e-77);
      8'd52: r = $realtobits(1e-76);   8'd53: r = $realtobits(1e-75);
      8'd54: r = $realtobits(1e-74);   8'd55: r = $realtobits(1e-73);
      8'd56: r = $realtobits(1e-72);   8'd57: r = $realtobits(1e-71);
      8'd58: r = $realtobits(1e-70);   8'd59: r = $realtobits(1e-69);
      8'd60: r = $realtobits(1e-68);   8'd61: r = $realtobits(1e-67);
      8'd62: r = $realtobits(1e-66);   8'd63: r = $realtobits(1e-65);
      8'd64: r = $realtobits(1e-64);   8'd65: r = $realtobits(1e-63);
      8'd66: r = $realtobits(1e-62);   8'd67: r = $realtobits(1e-61);
      8'd68: r = $realtobits(1e-60);   8'd69: r = $realtobits(1e-59);
      8'd70: r = $realtobits(1e-58);   8'd71: r = $realtobits(1e-57);
      8'd72: r = $realtobits(1e-56);   8'd73: r = $realtobits(1e-55);
      8'd74: r = $realtobits(1e-54);   8'd75: r = $realtobits(1e-53);
      8'd76: r = $realtobits(1e-52);   8'd77: r = $realtobits(1e-51);
      8'd78: r = $realtobits(1e-50);   8'd79: r = $realtobits(1e-49);
      8'd80: r = $realtobits(1e-48);   8'd81: r = $realtobits(1e-47);
      8'd82: r = $realtobits(1e-46);   8'd83: r = $realtobits(1e-45);
      8'd84: r = $realtobits(1e-44);   8'd85: r = $realtobits(1e-43);
      8'd86: r = $realtobits(1e-42);   8'd87: r = $realtobits(1e-41);
      8'd88: r = $realtobits(1e-40);   8'd89: r = $realtobits(1e-39);
      8'd90: r = $realtobits(1e-38);   8'd91: r = $realtobits(1e-37);
      8'd92: r = $realtobits(1e-36);   8'd93: r = $realtobits(1e-35);
      8'd94: r = $realtobits(1e-34);   8'd95: r = $realtobits(1e-33);
      8'd96: r = $realtobits(1e-32);   8'd97: r = $realtobits(1e-31);
      8'd98: r = $realtobits(1e-30);   8'd99: r = $realtobits(1e-29);
      8'd100: r = $realtobits(1e-28);  8'd101: r = $realtobits(1e-27);
      8'd102: r = $realtobits(1e-26);  8'd103: r = $realtobits(1e-25);
      8'd104: r = $realtobits(1e-24);  8'd105: r = $realtobits(1e-23);
      8'd106: r = $realtobits(1e-22);  8'd107: r = $realtobits(1e-21);
      8'd108: r = $realtobits(1e-20);  8'd109: r = $realtobits(1e-19);
      8'd110: r = $realtobits(1e-18);  8'd111: r = $realtobits(1e-17);
      8'd112: r = $realtobits(1e-16);  8'd113: r = $realtobits(1e-15);
      8'd114: r = $realtobits(1e-14);  8'd115: r = $realtobits(1e-13);
      8'd116: r = $realtobits(1e-12);  8'd117: r = $realtobits(1e-11);
      8'd118: r = $realtobits(1e-10);  8'd119: r = $realtobits(1e-9);
      8'd120: r = $realtobits(1e-8);   8'd121: r = $realtobits(1e-7);
      8'd122: r = $realtobits(1e-6);   8'd123: r = $realtobits(1e-5);
      8'd124: r = $realtobits(1e-4);   8'd125: r = $realtobits(1e-3);
      8'd126: r = $realtobits(1e-2);   8'd127: r = $realtobits(1e-1);
      8'd128: r = $realtobits(1e0);    8'd129: r = $realtobits(1e1);
      8'd130: r = $realtobits(1e2);    8'd131: r = $realtobits(1e3);
      8'd132: r = $realtobits(1e4);    8'd133: r = $realtobits(1e5);
      8'd134: r = $realtobits(1e6);    8'd135: r = $realtobits(1e7);
      8'd136: r = $realtobits(1e8);    8'd137: r = $realtobits(1e9);
      8'd138: r = $realtobits(1e10);   8'd139: r = $realtobits(1e11);
      8'd140: r = $realtobits(1e12);   8'd141: r = $realtobits(1e13);
      8'd142: r = $realtobits(1e14);   8'd143: r = $realtobits(1e15);
      8'd144: r = $realtobits(1e16);   8'd145: r = $realtobits(1e17);
      8'd146: r = $realtobits(1e18);   8'd147: r = $realtobits(1e19);
      8'd148: r = $realtobits(1e20);   8'd149: r = $realtobits(1e21);
      8'd150: r = $realtobits(1e22);   8'd151: r = $realtobits(1e23);
      8'd152: r = $realtobits(1e24);   8'd153: r = $realtobits(1e25);
      8'd154: r = $realtobits(1e26);   8'd155: r = $realtobits(1e27);
      8'd156: r = $realtobits(1e28);   8'd157: r = $realtobits(1e29);
      8'd158: r = $realtobits(1e30);   8'd159: r = $realtobits(1e31);
      8'd160: r = $realtobits(1e32);   8'd161: r = $realtobits(1e33);
      8'd162: r = $realtobits(1e34);   8'd163: r = $realtobits(1e35);
      8'd164: r = $realtobits(1e36);   8'd165: r = $realtobits(1e37);
      8'd166: r = $realtobits(1e38);   8'd167: r = $realtobits(1e39);
      8'd168: r = $realtobits(1e40);   8'd169: r = $realtobits(1e41);
      8'd170: r = $realtobits(1e42);   8'd171: r = $realtobits(1e43);
      8'd172: r = $realtobits(1e44);   8'd173: r = $realtobits(1e45);
      8'd174: r = $realtobits(1e46);   8'd175: r = $realtobits(1e47);
      8'd176: r = $realtobits(1e48);   8'd177: r = $realtobits(1e49);
      8'd178: r = $realtobits(1e50);   8'd179: r = $realtobits(1e51);
      8'd180: r = $realtobits(1e52);   8'd181: r = $realtobits(1e53);
      8'd182: r = $realtobits(1e54);   8'd183: r = $realtobits(1e55);
      8'd184: r = $realtobits(1e56);   8'd185: r = $realtobits(1e57);
      8'd186: r = $realtobits(1e58);   8'd187: r = $realtobits(1e59);
      8'd188: r = $realtobits(1e60);   8'd189: r = $realtobits(1e61);
      8'd190: r = $realtobits(1e62);   8'd191: r = $realtobits(1e63);
      8'd192: r = $realtobits(1e64);   8'd193: r = $realtobits(1e65);
      8'd194: r = $realtobits(1e66);   8'd195: r = $realtobits(1e67);
      8'd196: r = $realtobits(1e68);   8'd197: r = $realtobits(1e69);
      8'd198: r = $realtobits(1e70);   8'd199: r = $realtobits(1e71);
      8'd200: r = $realtobits(1e72);   8'd201: r = $realtobits(1e73);
      8'd202: r = $realtobits(1e74);   8'd203: r = $realtobits(1e75);
      8'd204: r = $realtobits(1e76);   8'd205: r = $realtobits(1e77);
      8'd206: r = $realtobits(1e78);   8'd207: r = $realtobits(1e79);
      8'd208: r = $realtobits(1e80);   8'd209: r = $realtobits(1e81);
      8'd210: r = $realtobits(1e82);   8'd211: r = $realtobits(1e83);
      8'd212: r = $realtobits(1e84);   8'd213: r = $realtobits(1e85);
      8'd214: r = $realtobits(1e86);   8'd215: r = $realtobits(1e87);
      8'd216: r = $realtobits(1e88);   8'd217: r = $realtobits(1e89);
      8'd218: r = $realtobits(1e90);   8'd219: r = $realtobits(1e91);
      8'd220: r = $realtobits(1e92);   8'd221: r = $realtobits(1e93);
      8'd222: r = $realtobits(1e94);   8'd223: r = $realtobits(1e95);
      8'd224: r = $realtobits(1e96);   8'd225: r = $realtobits(1e97);
      8'd226: r = $realtobits(1e98);   8'd227: r = $realtobits(1e99);
      8'd228: r = $realtobits(1e100);  8'd229: r = $realtobits(1e101);
      8'd230: r = $realtobits(1e102);  8'd231: r = $realtobits(1e103);
      8'd232: r = $realtobits(1e104);  8'd233: r = $realtobits(1e105);
      8'd234: r = $realtobits(1e106);  8'd235: r = $realtobits(1e107);
      8'd236: r = $realtobits(1e108);  8'd237: r = $realtobits(1e109);
      8'd238: r = $realtobits(1e110);  8'd239: r = $realtobits(1e111);
      8'd240: r = $realtobits(1e112);  8'd241: r = $realtobits(1e113);
      8'd242: r = $realtobits(1e114);  8'd243: r = $realtobits(1e115);
      8'd244: r = $realtobits(1e116);  8'd245: r = $realtobits(1e117);
      8'd246: r = $realtobits(1e118);  8'd247: r = $realtobits(1e119);
      8'd248: r = $realtobits(1e120);  8'd249: r = $realtobits(1e121);
      8'd250: r = $realtobits(1e122);  8'd251: r = $realtobits(1e123);
      8'd252: r = $realtobits(1e124);  8'd253: r = $realtobits(1e125);
      8'd254: r = $realtobits(1e126);  8'd255: r = $realtobits(1e127);
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/medical_float_to_double_decoder.sv =====
// Decodes one SFLOAT or FLOAT item per clock into a binary64 pattern. busy is
// always low; each result appears on out_result_bits with out_strobe high for
// one cycle, after the registered stages of decode and table lookup, split
// multiply, and normalize and round. The receiver cannot stall the output,
// so results must be captured when out_strobe is high.
module medical_float_to_double_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_command,
  input  logic [31:0] in_raw_word,
  output logic        out_strobe,
  output logic [63:0] out_result_bits,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_byte_order_big
);
  import mfd_pkg::*;

  logic        order_r;

  // stage 1
  logic        v1_r, v1_nxt;
  logic        spec1_r, spec1_nxt;
  logic [63:0] sbits1_r, sbits1_nxt;
  logic        sign1_r, sign1_nxt;
  logic [23:0] mag1_r, mag1_nxt;
  logic [63:0] tbits1_r, tbits1_nxt;

  // stage 2
  logic        v2_r;
  logic        spec2_r;
  logic [63:0] sbits2_r;
  logic        sign2_r;
  logic [10:0] texp2_r;
  logic [4:0]  d02_r, d0_nxt;
  logic [50:0] pp_lo2_r;
  logic [49:0] pp_hi2_r;

  // stage 3
  logic        v3_r;
  logic [63:0] res_r, res_nxt;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      order_r <= cfg_byte_order_big;
    end
  end

  always_comb begin
    logic [15:0] w16;
    logic [31:0] w32;
    logic [23:0] m;
    logic [7:0]  e;
    w16 = in_raw_word[15:0];
    w32 = in_raw_word;
    if (order_r) begin
      w16 = {w16[7:0], w16[15:8]};
      w32 = {w32[7:0], w32[15:8], w32[23:16], w32[31:24]};
    end
    if (in_command == CMD_SFLOAT) begin
      m = {{12{w16[11]}}, w16[11:0] & SF_MANT_MASK};
      e = {{4{w16[15]}}, w16[15:12]};
    end else begin
      m = w32[23:0];
      e = w32[31:24];
    end
    v1_nxt = start && !busy;
    spec1_nxt = 1'b0;
    sbits1_nxt = BITS_QNAN;
    if (in_command == CMD_FLOAT) begin
      if (m == FL_POS_INF) begin
        spec1_nxt = 1'b1;
        sbits1_nxt = BITS_POS_INF;
      end else if (m >= FL_NAN_LO && m <= FL_NAN_HI) begin
        spec1_nxt = 1'b1;
      end else if (m == FL_NEG_INF) begin
        spec1_nxt = 1'b1;
        sbits1_nxt = BITS_NEG_INF;
      end
    end
    if (m == 24'd0) begin
      spec1_nxt = 1'b1;
      sbits1_nxt = 64'd0;
    end
    sign1_nxt = m[23];
    mag1_nxt = m[23] ? (~m + 24'd1) : m;
    tbits1_nxt = pow10_bits({~e[7], e[6:0]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    spec1_r <= spec1_nxt;
    sbits1_r <= sbits1_nxt;
    sign1_r <= sign1_nxt;
    mag1_r <= mag1_nxt;
    tbits1_r <= tbits1_nxt;
  end

  // leading one of the magnitude
  always_comb begin
    d0_nxt = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (mag1_r[i]) begin
        d0_nxt = 5'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    spec2_r <= spec1_r;
    sbits2_r <= sbits1_r;
    sign2_r <= sign1_r;
    texp2_r <= tbits1_r[62:52];
    d02_r <= d0_nxt;
    pp_lo2_r <= mag1_r * tbits1_r[26:0];
    pp_hi2_r <= mag1_r * {1'b1, tbits1_r[51:27]};
  end

  always_comb begin
    logic [76:0]  prod;
    logic [4:0]   d;
    logic [76:0]  al;
    logic         g;
    logic         stk;
    logic         inc;
    logic [10:0]  ex;
    prod = {27'd0, pp_hi2_r} << 27;
    prod = prod + {26'd0, pp_lo2_r};
    d = prod[7'd53 + {2'd0, d02_r}] ? d02_r + 5'd1 : d02_r;
    al = prod << (5'd24 - d);
    g = al[23];
    stk = |al[22:0];
    inc = g && (stk || al[24]);
    ex = texp2_r + {6'd0, d};
    if (spec2_r) begin
      res_nxt = sbits2_r;
    end else begin
      res_nxt = {sign2_r, {ex, al[75:24]} + {62'd0, inc}};
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_strobe = v3_r;
  assign out_result_bits = res_r;

endmodule
